@@ design/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; imported by the console top level and its checker.
package tcw_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned RowW  = 5;
  localparam int unsigned ColW  = 7;
  localparam int unsigned CellW = 16;

  localparam logic [ByteW-1:0] NewlineCode = 8'h0A;
  localparam logic [ByteW-1:0] BlankCode   = 8'h20;
  localparam logic [ByteW-1:0] ResetColor  = 8'h0F;

  typedef enum logic [CmdW-1:0] {
    CMD_PUT    = 3'd0,
    CMD_PUT_AT = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_COLOR  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_FILL = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_READ = 4'b0100,
    ST_COPY = 4'b1000
  } state_e;

endpackage

@@ design/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/text_console_writer.sv @@
// Text console writer: a COLUMNS x ROWS character-cell screen held in one RAM, one 16-bit
// word per cell (character in 7:0, color in 15:8). Every accepted item yields exactly one
// result that reports the cursor. A put that does not scroll, a set-color, or an
// out-of-range access finishes in the accept cycle and frees the input for the next item
// unless the result stalls; an in-range cell read passes through ST_READ because of the
// RAM's registered read. Clear sweeps all COLUMNS*ROWS cells at one write per cycle; a
// scroll copies COLUMNS*(ROWS-1) cells (one RAM read and one write per cycle, each write
// registered behind its read) and then blanks the bottom row. After reset the same sweep
// fills the screen with 0x0F20, so input is held off until it is done. The result of a
// clear or scroll is posted at accept time; the next item waits until the sweep is done.
// Depends on tcw_pkg and tcw_ram.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tcw_pkg::CmdW-1:0]    command_i,
  input  logic [tcw_pkg::ByteW-1:0]   char_code_i,
  input  logic [tcw_pkg::ByteW-1:0]   entry_color_i,
  input  logic [tcw_pkg::ByteW-1:0]   column_i,
  input  logic [tcw_pkg::ByteW-1:0]   row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcw_pkg::RowW-1:0]    cursor_row_o,
  output logic [tcw_pkg::ColW-1:0]    cursor_column_o,
  output logic [tcw_pkg::CellW-1:0]   cell_word_o,
  output logic                        ignored_o,
  output logic                        scrolled_o
);
  import tcw_pkg::*;

  localparam int unsigned Cells = COLUMNS * ROWS;
  localparam int unsigned AddrW = (Cells > 1) ? $clog2(Cells) : 1;

  localparam logic [AddrW-1:0] LastAddr   = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] BottomAddr = AddrW'(Cells - COLUMNS);
  localparam logic [AddrW-1:0] RowStride  = AddrW'(COLUMNS);
  localparam logic [ByteW:0]   ColLimit   = (ByteW+1)'(COLUMNS);
  localparam logic [RowW:0]    RowLimit   = (RowW+1)'(ROWS);

  // Sequencer and sweep pointer
  state_e             state_q, state_d;
  logic [AddrW-1:0]   ptr_q, ptr_d;
  logic [CellW-1:0]   fill_q, fill_d;
  // Copy pipeline: write of the cell read in the previous cycle
  logic               wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]   wr_addr_q, wr_addr_d;

  // Console state
  logic [RowW-1:0]    line_q, line_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [ByteW-1:0]   color_q, color_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [RowW-1:0]    out_row_q, out_row_d;
  logic [ColW-1:0]    out_col_q, out_col_d;
  logic [CellW-1:0]   out_cell_q, out_cell_d;
  logic               out_ign_q, out_ign_d;
  logic               out_scr_q, out_scr_d;

  // RAM port
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [CellW-1:0]   ram_wdata, ram_rdata;

  // Decode of the incoming item
  cmd_e               cmd;
  logic               in_accept;
  logic               in_range;
  logic [AddrW-1:0]   tgt_addr, cur_addr;
  logic [ByteW:0]     col_inc;
  logic [RowW:0]      line_inc;
  logic               is_newline, wrap, scroll;
  logic [RowW-1:0]    put_line;
  logic [ColW-1:0]    put_col;

  assign cmd       = cmd_e'(command_i);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_accept = in_valid_i && in_ready_o;

  assign in_range = ({1'b0, column_i} < ColLimit) && ({1'b0, row_i} < (ByteW+1)'(ROWS));
  // Only used when in range, so the low bits carry the whole coordinate
  assign tgt_addr = AddrW'(int'(row_i[RowW-1:0]) * COLUMNS + int'(column_i[ColW-1:0]));
  assign cur_addr = AddrW'(int'(line_q) * COLUMNS + int'(col_q));

  // Cursor advance for a put at the cursor
  assign col_inc    = (ByteW+1)'(col_q) + 1'b1;
  assign line_inc   = {1'b0, line_q} + 1'b1;
  assign is_newline = (char_code_i == NewlineCode);
  assign wrap       = is_newline || (col_inc >= ColLimit);
  assign scroll     = wrap && (line_inc >= RowLimit);
  assign put_line   = (wrap && !scroll) ? line_inc[RowW-1:0] : line_q;
  assign put_col    = wrap ? '0 : col_inc[ColW-1:0];

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = ptr_q - RowStride;
    line_d      = line_q;
    col_d       = col_q;
    color_d     = color_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_cell_d  = out_cell_q;
    out_ign_d   = out_ign_q;
    out_scr_d   = out_scr_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = fill_q;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    case (state_q)
      ST_FILL: begin
        // A copy write left over from the scroll takes the port first
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end else begin
          ram_we = 1'b1;
          ptr_d  = ptr_q + 1'b1;
          if (ptr_q == LastAddr) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_COPY: begin
        ram_re    = 1'b1;
        wr_pend_d = 1'b1;
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        if (ptr_q == LastAddr) begin
          state_d = ST_FILL;
          ptr_d   = BottomAddr;
          fill_d  = {color_q, BlankCode};
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_READ: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_cell_d  = ram_rdata;
      end

      ST_IDLE: begin
        if (in_accept) begin
          out_valid_d = 1'b1;
          out_cell_d  = '0;
          out_ign_d   = 1'b0;
          out_scr_d   = 1'b0;
          case (cmd)
            CMD_PUT: begin
              if (!is_newline) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {color_q, char_code_i};
              end
              line_d    = put_line;
              col_d     = put_col;
              out_scr_d = scroll;
              if (scroll) begin
                state_d = ST_COPY;
                ptr_d   = RowStride;
              end
            end
            CMD_PUT_AT: begin
              if (in_range) begin
                ram_we    = 1'b1;
                ram_waddr = tgt_addr;
                ram_wdata = {entry_color_i, char_code_i};
              end else begin
                out_ign_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              line_d  = '0;
              col_d   = '0;
              color_d = entry_color_i;
              state_d = ST_FILL;
              ptr_d   = '0;
              fill_d  = {entry_color_i, BlankCode};
            end
            CMD_COLOR: begin
              color_d = entry_color_i;
            end
            CMD_READ: begin
              if (in_range) begin
                // Result is posted from ST_READ, once the registered RAM data is there
                ram_re      = 1'b1;
                ram_raddr   = tgt_addr;
                out_valid_d = 1'b0;
                state_d     = ST_READ;
              end else begin
                out_ign_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
          out_row_d = line_d;
          out_col_d = col_d;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      ptr_q       <= '0;
      fill_q      <= {ResetColor, BlankCode};
      wr_pend_q   <= 1'b0;
      line_q      <= '0;
      col_q       <= '0;
      color_q     <= ResetColor;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      wr_pend_q   <= wr_pend_d;
      line_q      <= line_d;
      col_q       <= col_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_cell_q <= out_cell_d;
    out_ign_q  <= out_ign_d;
    out_scr_q  <= out_scr_d;
  end

  tcw_ram #(
    .Width (CellW),
    .Depth (Cells)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_column_o = out_col_q;
  assign cell_word_o     = out_cell_q;
  assign ignored_o       = out_ign_q;
  assign scrolled_o      = out_scr_q;

endmodule

@@ design/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to its top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tcw_pkg::RowW-1:0]    cursor_row_o,
  input logic [tcw_pkg::ColW-1:0]    cursor_column_o,
  input logic [tcw_pkg::CellW-1:0]   cell_word_o,
  input logic                        ignored_o,
  input logic                        scrolled_o
);
  import tcw_pkg::*;

  // Held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({cursor_row_o, cursor_column_o, cell_word_o, ignored_o, scrolled_o}))
    else $error("result changed while stalled");

  // Input only taken when the result slot frees up
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input ready with result slot blocked");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_column_o) < COLUMNS) && (int'(cursor_row_o) < ROWS))
    else $error("cursor out of screen");

  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> (int'(cursor_row_o) == ROWS - 1) &&
      (cursor_column_o == '0) && !ignored_o && (cell_word_o == '0))
    else $error("scroll result not at bottom row start");

  a_ignored_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ignored_o |-> (cell_word_o == '0) && !scrolled_o)
    else $error("ignored access returned data");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .cursor_row_o    (cursor_row_o),
  .cursor_column_o (cursor_column_o),
  .cell_word_o     (cell_word_o),
  .ignored_o       (ignored_o),
  .scrolled_o      (scrolled_o)
);

@@ tb/text_console_writer_test.sv @@
// Self-checking bench for text_console_writer: directed table, then random command streams.
// Expected reports come from a cell-accurate screen model kept in this file, or from the table.
// Depends on tcw_pkg and the design sources only.
`timescale 1ns / 100ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  // Command codes the block does not decode; they must leave everything alone.
  localparam logic [CmdW-1:0] OpUnused5 = 3'd5;
  localparam logic [CmdW-1:0] OpUnused6 = 3'd6;
  localparam logic [CmdW-1:0] OpUnused7 = 3'd7;

  localparam int DirectedCount = 25;
  localparam int RandomItems   = 900;
  // Clears and scrolls each sweep the whole screen; cap them to keep the run short.
  localparam int SweepBudget   = 200;
  localparam int DrainCycles   = CELLS + 50;

  typedef struct packed {
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [CellW-1:0] word;
    logic             ignored;
    logic             scrolled;
  } console_result_t;

  typedef struct packed {
    logic [CmdW-1:0]  op;
    logic [ByteW-1:0] ch;
    logic [ByteW-1:0] color;
    logic [ByteW-1:0] col;
    logic [ByteW-1:0] row;
    logic             fixed;   // use the typed-in report instead of the model's
    console_result_t  want;
  } stim_row_t;

  // Reports that can be read straight off the screen state at a glance.
  localparam console_result_t HomeNothing    = '0;
  localparam console_result_t HomeResetCell  = '{5'd0, 7'd0, 16'h0F20, 1'b0, 1'b0};
  localparam console_result_t HomeMaxCell    = '{5'd0, 7'd0, 16'hFFFF, 1'b0, 1'b0};
  localparam console_result_t HomeBlackBlank = '{5'd0, 7'd0, 16'h0020, 1'b0, 1'b0};
  localparam console_result_t HomeIgnored    = '{5'd0, 7'd0, 16'h0000, 1'b1, 1'b0};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i;
  logic [ByteW-1:0]    char_code_i;
  logic [ByteW-1:0]    entry_color_i;
  logic [ByteW-1:0]    column_i;
  logic [ByteW-1:0]    row_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [RowW-1:0]     cursor_row_o;
  logic [ColW-1:0]     cursor_column_o;
  logic [CellW-1:0]    cell_word_o;
  logic                ignored_o;
  logic                scrolled_o;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .char_code_i    (char_code_i),
    .entry_color_i  (entry_color_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_row_o   (cursor_row_o),
    .cursor_column_o(cursor_column_o),
    .cell_word_o    (cell_word_o),
    .ignored_o      (ignored_o),
    .scrolled_o     (scrolled_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Screen model: cells, cursor and current color, advanced once per item.
  // ---------------------------------------------------------------------------
  logic [CellW-1:0] screen_model [CELLS];
  int unsigned      cur_row;
  int unsigned      cur_col;
  logic [ByteW-1:0] cur_color;

  console_result_t  expected_reports [$];
  int               fail_count;
  int               shown;
  int               sweeps_left;
  int               random_sent;
  bit               quiet;       // both sides stop idling while set

  function automatic void fill_model(input logic [ByteW-1:0] color);
    for (int i = 0; i < CELLS; i++) screen_model[i] = {color, BlankCode};
  endfunction

  // Row advance: column to 0; at the bottom row the screen shifts up a row and
  // the new bottom row is blanked in the current color.
  function automatic logic next_line();
    cur_col = 0;
    if (cur_row < ROWS - 1) begin
      cur_row++;
      return 1'b0;
    end
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {cur_color, BlankCode};
    return 1'b1;
  endfunction

  function automatic console_result_t predict_console(input logic [CmdW-1:0] op,
                                                      input logic [ByteW-1:0] ch,
                                                      input logic [ByteW-1:0] color,
                                                      input logic [ByteW-1:0] col,
                                                      input logic [ByteW-1:0] row);
    console_result_t res;
    bit              hit;
    int unsigned     spot;
    res  = '0;
    hit  = (col < COLUMNS) && (row < ROWS);
    spot = row * COLUMNS + col;
    case (op)
      CMD_PUT: begin
        if (ch == NewlineCode) begin
          res.scrolled = next_line();
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {cur_color, ch};
          cur_col++;
          if (cur_col >= COLUMNS) res.scrolled = next_line();
        end
      end
      CMD_PUT_AT: begin
        // a newline byte is stored as plain data here
        if (hit) screen_model[spot] = {color, ch};
        else res.ignored = 1'b1;
      end
      CMD_CLEAR: begin
        cur_row   = 0;
        cur_col   = 0;
        cur_color = color;
        fill_model(color);
      end
      CMD_COLOR: cur_color = color;
      CMD_READ: begin
        if (hit) res.word = screen_model[spot];
        else res.ignored = 1'b1;
      end
      default: ;
    endcase
    res.row = RowW'(cur_row);
    res.col = ColW'(cur_col);
    return res;
  endfunction

  function automatic bit makes_sweep(input logic [CmdW-1:0] op, input logic [ByteW-1:0] ch);
    if (op == CMD_CLEAR) return 1'b1;
    return op == CMD_PUT && cur_row == ROWS - 1 &&
           (ch == NewlineCode || cur_col == COLUMNS - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge; returns at the falling edge after the
  // item was taken. Random idle cycles go in front of the item.
  // ---------------------------------------------------------------------------
  task automatic send_command(input logic [CmdW-1:0] op, input logic [ByteW-1:0] ch,
                              input logic [ByteW-1:0] color, input logic [ByteW-1:0] col,
                              input logic [ByteW-1:0] row, input bit fixed,
                              input console_result_t want);
    console_result_t model_out;
    model_out = predict_console(op, ch, color, col, row);
    // the report can only come after the accept, so queue it now
    expected_reports.push_back(fixed ? want : model_out);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= op;
    char_code_i   <= ch;
    entry_color_i <= color;
    column_i      <= col;
    row_i         <= row;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Random-stream entry point: enforces the sweep budget, and opens a stretch
  // with no idling on either side partway through.
  task automatic issue(input logic [CmdW-1:0] op, input logic [ByteW-1:0] ch,
                       input logic [ByteW-1:0] color, input logic [ByteW-1:0] col,
                       input logic [ByteW-1:0] row);
    logic [CmdW-1:0] op_now;
    op_now = op;
    if (makes_sweep(op, ch)) begin
      if (sweeps_left == 0) op_now = CMD_PUT_AT;
      else sweeps_left--;
    end
    quiet = (random_sent >= 300) && (random_sent < 420);
    send_command(op_now, ch, color, col, row, 1'b0, HomeNothing);
    random_sent++;
  endtask

  // Mostly on-screen coordinates, sometimes anywhere in the 8-bit range.
  function automatic logic [ByteW-1:0] pick_coord(input int unsigned limit);
    if ($urandom_range(99) < 20) return ByteW'($urandom_range(255));
    return ByteW'($urandom_range(limit - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready toggles at falling edges, reports checked at rising edges.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= quiet || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin : check_reports
    console_result_t got;
    console_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {cursor_row_o, cursor_column_o, cell_word_o, ignored_o, scrolled_o};
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (shown < 10) begin
          shown++;
          $display("unexpected report: row %0d col %0d cell %h ign %b scr %b",
                   got.row, got.col, got.word, got.ignored, got.scrolled);
        end
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected row %0d col %0d cell %h ign %b scr %b",
                     want.row, want.col, want.word, want.ignored, want.scrolled);
            $display("          actual   row %0d col %0d cell %h ign %b scr %b",
                     got.row, got.col, got.word, got.ignored, got.scrolled);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  stim_row_t directed_table [DirectedCount];

  initial begin : main_sequence
    stim_row_t        r;
    int               seg_kind;
    int               n;
    logic [ByteW-1:0] col;
    logic [ByteW-1:0] row;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_PUT;
    char_code_i   = '0;
    entry_color_i = '0;
    column_i      = '0;
    row_i         = '0;
    fail_count    = 0;
    shown         = 0;
    sweeps_left   = SweepBudget;
    random_sent   = 0;
    quiet         = 1'b0;

    cur_row   = 0;
    cur_col   = 0;
    cur_color = ResetColor;
    fill_model(ResetColor);

    directed_table = '{
      // power-up screen at both corners
      '{CMD_READ,   8'h00, 8'h00, 8'd0,   8'd0,   1'b1, HomeResetCell},
      '{CMD_READ,   8'h00, 8'h00, 8'd79,  8'd24,  1'b1, HomeResetCell},
      // targets just past the screen and at the far end of the field; all-ones cell at the corner
      '{CMD_READ,   8'h00, 8'h00, 8'd80,  8'd0,   1'b1, HomeIgnored},
      '{CMD_READ,   8'h00, 8'h00, 8'd0,   8'd25,  1'b1, HomeIgnored},
      '{CMD_READ,   8'hFF, 8'hFF, 8'd255, 8'd255, 1'b1, HomeIgnored},
      '{CMD_PUT_AT, 8'hFF, 8'hFF, 8'd79,  8'd24,  1'b1, HomeNothing},
      '{CMD_READ,   8'h00, 8'h00, 8'd79,  8'd24,  1'b1, HomeMaxCell},
      '{CMD_PUT_AT, 8'hFF, 8'hFF, 8'd255, 8'd0,   1'b1, HomeIgnored},
      '{CMD_PUT_AT, 8'h00, 8'h00, 8'd0,   8'd255, 1'b1, HomeIgnored},
      // newline byte written at a cell is plain data
      '{CMD_PUT_AT, 8'h0A, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing},
      '{CMD_READ,   8'h00, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing},
      // cursor writes, a newline, a color change, a read-back
      '{CMD_PUT,    8'h00, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing},
      '{CMD_PUT,    8'hFF, 8'hFF, 8'd255, 8'd255, 1'b0, HomeNothing},
      '{CMD_PUT,    8'h0A, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing},
      '{CMD_COLOR,  8'h00, 8'hA5, 8'd0,   8'd0,   1'b0, HomeNothing},
      '{CMD_PUT,    8'h41, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing},
      '{CMD_READ,   8'h00, 8'h00, 8'd0,   8'd1,   1'b0, HomeNothing},
      // undecoded commands
      '{OpUnused5,  8'hFF, 8'hFF, 8'd255, 8'd255, 1'b0, HomeNothing},
      '{OpUnused6,  8'h0A, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing},
      '{OpUnused7,  8'h55, 8'hAA, 8'd10,  8'd10,  1'b0, HomeNothing},
      // clears to both color extremes, then a put and its read-back
      '{CMD_CLEAR,  8'hFF, 8'h00, 8'd255, 8'd255, 1'b1, HomeNothing},
      '{CMD_READ,   8'h00, 8'h00, 8'd40,  8'd12,  1'b1, HomeBlackBlank},
      '{CMD_CLEAR,  8'h00, 8'hFF, 8'd0,   8'd0,   1'b1, HomeNothing},
      '{CMD_PUT,    8'h5A, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing},
      '{CMD_READ,   8'h00, 8'h00, 8'd0,   8'd0,   1'b0, HomeNothing}
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DirectedCount; i++) begin
      r = directed_table[i];
      send_command(r.op, r.ch, r.color, r.col, r.row, r.fixed, r.want);
    end

    // Random part, built from segments: text lines that wrap and scroll, runs of
    // newlines, write/read-back pairs, reads near the cursor, color changes,
    // clears, and short bursts of raw noise on every field.
    while (random_sent < RandomItems) begin
      seg_kind = $urandom_range(99);
      if (seg_kind < 40) begin
        n = $urandom_range(100);
        for (int k = 0; k < n; k++)
          issue(CMD_PUT, ByteW'($urandom_range(255)), ByteW'($urandom), 8'd0, 8'd0);
        if ($urandom_range(99) < 75) issue(CMD_PUT, NewlineCode, 8'd0, 8'd0, 8'd0);
      end else if (seg_kind < 55) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
          issue(CMD_PUT, NewlineCode, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
      end else if (seg_kind < 72) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          col = pick_coord(COLUMNS);
          row = pick_coord(ROWS);
          issue(CMD_PUT_AT, ByteW'($urandom), ByteW'($urandom), col, row);
          issue(CMD_READ, ByteW'($urandom), ByteW'($urandom), col, row);
        end
      end else if (seg_kind < 80) begin
        // look at what the cursor just wrote, or what a scroll just moved
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          row = ByteW'(cur_row);
          if (cur_row > 0 && $urandom_range(1) == 1) row = ByteW'(cur_row - 1);
          issue(CMD_READ, 8'd0, 8'd0, ByteW'($urandom_range(COLUMNS - 1)), row);
        end
      end else if (seg_kind < 90) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          issue(CmdW'($urandom_range(7)), ByteW'($urandom), ByteW'($urandom),
                ByteW'($urandom), ByteW'($urandom));
      end else if (seg_kind < 97) begin
        issue(CMD_COLOR, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
              ByteW'($urandom));
      end else begin
        issue(CMD_CLEAR, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
              ByteW'($urandom));
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then give a trailing sweep time to finish before the verdict.
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("text_console_writer_test OK");
    end else begin
      $display("text_console_writer_test NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (reset fill, capped sweeps,
  // random stalls on both sides).
  initial begin
    #6_000_000;
    $display("text_console_writer_test NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer.sv
design/tcw_checker.sv
tb/text_console_writer_test.sv
